[rtl/srfr_pkg.sv]
package srfr_pkg;

  // Frame layout
  localparam int END_POSITION = 10;
  localparam int SUM_FIRST    = 1;
  localparam int SUM_LAST     = 6;
  localparam int CMD_POS      = 3;
  localparam int DEV_POS      = 6;
  localparam int CHK_HI_POS   = 7;
  localparam int CHK_LO_POS   = 8;

  localparam int POS_LIMIT   = END_POSITION + 1;
  localparam int STORE_DEPTH = (END_POSITION + 2) > 9 ? (END_POSITION + 2) : 9;
  localparam int POS_W       = $clog2(POS_LIMIT + 1);

  localparam int BYTE_W   = 8;
  localparam int CHK_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_VALUE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONLINE_COMMAND = 2'd2;

  localparam logic [BYTE_W-1:0] START_VALUE_RST    = 8'd126;
  localparam logic [BYTE_W-1:0] END_VALUE_RST      = 8'd239;
  localparam logic [BYTE_W-1:0] ONLINE_COMMAND_RST = 8'd63;

  localparam logic [BYTE_W-1:0] COUNT_MAX = 8'd255;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_ONLINE    = 2'd0,
    ST_OTHER     = 2'd1,
    ST_CHK_ERR   = 2'd2,
    ST_NOT_FIRST = 2'd3
  } status_t;

  // One completed frame, as classified by the front end
  typedef struct packed {
    logic              chk_ok;
    logic              cmd_match;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] dev;
  } frame_rec_t;

  // Queue state seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[rtl/serial_reply_frame_receiver_top.sv]
// Takes one byte per cycle; in_ready drops only while the two-entry frame queue is full.
// A byte that completes a frame is classified at acceptance and queued; its result is
// then popped from the queue into the output register that drives the outputs, unless
// out_ready stalls the back end; other bytes yield none.
// Synchronous reset clears byte position, frame counter, player ready and the queue,
// and loads the register defaults; the frame byte store is not cleared.
module serial_reply_frame_receiver_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [srfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srfr_pkg::BYTE_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [srfr_pkg::BYTE_W-1:0]       rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [srfr_pkg::BYTE_W-1:0]       command_byte,
  output logic [srfr_pkg::BYTE_W-1:0]       device_mask,
  output logic [srfr_pkg::BYTE_W-1:0]       frames_seen,
  output logic                              ready_flag
);

  srfr_pkg::queue_stat_t q_stat;
  srfr_pkg::frame_rec_t  push_rec;
  srfr_pkg::frame_rec_t  pop_rec;
  logic                  push;
  logic                  pop;

  srfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .q_stat    (q_stat),
    .push      (push),
    .push_rec  (push_rec)
  );

  srfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .q_stat   (q_stat)
  );

  srfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .pop_rec      (pop_rec),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .command_byte (command_byte),
    .device_mask  (device_mask),
    .frames_seen  (frames_seen),
    .ready_flag   (ready_flag)
  );

endmodule

[rtl/srfr_front.sv]
module srfr_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [srfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srfr_pkg::BYTE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [srfr_pkg::BYTE_W-1:0]         rx_byte,
  input  srfr_pkg::queue_stat_t               q_stat,
  output logic                                push,
  output srfr_pkg::frame_rec_t                push_rec
);

  logic [srfr_pkg::BYTE_W-1:0] start_value;
  logic [srfr_pkg::BYTE_W-1:0] end_value;
  logic [srfr_pkg::BYTE_W-1:0] online_command;

  logic [srfr_pkg::POS_W-1:0]  position;
  logic [srfr_pkg::POS_W-1:0]  position_next;
  logic [srfr_pkg::BYTE_W-1:0] store [srfr_pkg::STORE_DEPTH];
  logic [srfr_pkg::BYTE_W-1:0] view  [srfr_pkg::STORE_DEPTH];
  logic [srfr_pkg::CHK_W-1:0]  sum;
  logic [srfr_pkg::CHK_W-1:0]  expect_word;
  logic                        accept;
  logic                        done;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (rx_byte == start_value) begin
      position_next = '0;
    end else if (position < srfr_pkg::POS_W'(srfr_pkg::POS_LIMIT)) begin
      position_next = position + 1'b1;
    end else begin
      position_next = position;
    end

    // Store contents as they stand once this byte is written
    view = store;
    view[position_next] = rx_byte;

    done = (rx_byte == end_value) &&
           (position_next == srfr_pkg::POS_W'(srfr_pkg::END_POSITION));

    sum = '0;
    for (int i = srfr_pkg::SUM_FIRST; i <= srfr_pkg::SUM_LAST; i++) begin
      sum = sum + srfr_pkg::CHK_W'(view[i]);
    end
    expect_word = {view[srfr_pkg::CHK_HI_POS], view[srfr_pkg::CHK_LO_POS]};

    push_rec.chk_ok    = ((srfr_pkg::CHK_W'(0) - sum) == expect_word);
    push_rec.cmd_match = (view[srfr_pkg::CMD_POS] == online_command);
    push_rec.cmd       = view[srfr_pkg::CMD_POS];
    push_rec.dev       = view[srfr_pkg::DEV_POS];
    push               = accept && done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value    <= srfr_pkg::START_VALUE_RST;
      end_value      <= srfr_pkg::END_VALUE_RST;
      online_command <= srfr_pkg::ONLINE_COMMAND_RST;
      position       <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          srfr_pkg::REG_START_VALUE:    start_value    <= cfg_data;
          srfr_pkg::REG_END_VALUE:      end_value      <= cfg_data;
          srfr_pkg::REG_ONLINE_COMMAND: online_command <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        position <= position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store[position_next] <= rx_byte;
    end
  end

endmodule

[rtl/srfr_queue.sv]
module srfr_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  srfr_pkg::frame_rec_t  push_rec,
  input  logic                  pop,
  output srfr_pkg::frame_rec_t  pop_rec,
  output srfr_pkg::queue_stat_t q_stat
);

  srfr_pkg::frame_rec_t         entries [srfr_pkg::QUEUE_DEPTH];
  logic [srfr_pkg::QPTR_W-1:0]  wr_ptr;
  logic [srfr_pkg::QPTR_W-1:0]  rd_ptr;
  logic [srfr_pkg::QCNT_W-1:0]  count;

  assign q_stat.full  = (count == srfr_pkg::QCNT_W'(srfr_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_rec      = entries[rd_ptr];

  function automatic logic [srfr_pkg::QPTR_W-1:0] ptr_inc(
    input logic [srfr_pkg::QPTR_W-1:0] p
  );
    if (p == srfr_pkg::QPTR_W'(srfr_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

[rtl/srfr_back.sv]
module srfr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  srfr_pkg::queue_stat_t         q_stat,
  input  srfr_pkg::frame_rec_t          pop_rec,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [srfr_pkg::BYTE_W-1:0]   command_byte,
  output logic [srfr_pkg::BYTE_W-1:0]   device_mask,
  output logic [srfr_pkg::BYTE_W-1:0]   frames_seen,
  output logic                          ready_flag
);

  logic [srfr_pkg::BYTE_W-1:0] frame_counter;
  logic [srfr_pkg::BYTE_W-1:0] frame_counter_next;
  logic                        player_ready;
  logic                        player_ready_next;
  srfr_pkg::status_t           status_next;
  srfr_pkg::status_t           status_reg;

  assign pop    = !q_stat.empty && (!out_valid || out_ready);
  assign status = status_reg;

  always_comb begin
    frame_counter_next = (frame_counter < srfr_pkg::COUNT_MAX) ?
                         frame_counter + 1'b1 : frame_counter;
    player_ready_next  = player_ready;
    // Only the very first frame is judged
    if (frame_counter != '0) begin
      status_next = srfr_pkg::ST_NOT_FIRST;
    end else if (!pop_rec.chk_ok) begin
      status_next = srfr_pkg::ST_CHK_ERR;
    end else if (pop_rec.cmd_match) begin
      status_next       = srfr_pkg::ST_ONLINE;
      player_ready_next = 1'b1;
    end else begin
      status_next = srfr_pkg::ST_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      frame_counter <= '0;
      player_ready  <= 1'b0;
    end else begin
      if (pop) begin
        out_valid     <= 1'b1;
        frame_counter <= frame_counter_next;
        player_ready  <= player_ready_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_reg   <= status_next;
      command_byte <= pop_rec.cmd;
      device_mask  <= pop_rec.dev;
      frames_seen  <= frame_counter_next;
      ready_flag   <= player_ready_next;
    end
  end

endmodule

[tb/serial_reply_frame_receiver_top_test.sv]
`timescale 1ns / 1ps

module serial_reply_frame_receiver_top_test;

  typedef struct {
    srfr_pkg::status_t           st;
    logic [srfr_pkg::BYTE_W-1:0] cmd;
    logic [srfr_pkg::BYTE_W-1:0] dev;
    logic [srfr_pkg::BYTE_W-1:0] count;
    logic                        rdy;
  } frame_reply_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [srfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [srfr_pkg::BYTE_W-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [srfr_pkg::BYTE_W-1:0]    rx_byte = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     status;
  logic [srfr_pkg::BYTE_W-1:0]    command_byte;
  logic [srfr_pkg::BYTE_W-1:0]    device_mask;
  logic [srfr_pkg::BYTE_W-1:0]    frames_seen;
  logic                           ready_flag;

  // Register copies and frame tracking state, mirroring the block
  logic [srfr_pkg::BYTE_W-1:0] cur_start = srfr_pkg::START_VALUE_RST;
  logic [srfr_pkg::BYTE_W-1:0] cur_end = srfr_pkg::END_VALUE_RST;
  logic [srfr_pkg::BYTE_W-1:0] cur_online = srfr_pkg::ONLINE_COMMAND_RST;
  logic [srfr_pkg::POS_W-1:0]  rx_pos = '0;
  logic [srfr_pkg::BYTE_W-1:0] frame_bytes [srfr_pkg::STORE_DEPTH];
  logic [srfr_pkg::BYTE_W-1:0] frames_done = '0;
  logic                        player_ready = 1'b0;

  logic [srfr_pkg::BYTE_W-1:0] pending_bytes [$];
  frame_reply_t                expected_replies [$];

  int  errors = 0;
  int  bytes_queued = 0;
  int  bytes_taken = 0;
  int  replies_checked = 0;
  int  past_saturation = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  bit  calm = 1'b0;

  serial_reply_frame_receiver_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .command_byte (command_byte),
    .device_mask  (device_mask),
    .frames_seen  (frames_seen),
    .ready_flag   (ready_flag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d frame replies still outstanding", expected_replies.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("frame reply %0d, %s: got %0d, expected %0d (t=%0t)",
             replies_checked, what, got, want, $realtime);
    errors++;
  endtask

  // Advance the frame position on one accepted byte and queue any reply it completes
  task automatic track_rx_byte(input logic [srfr_pkg::BYTE_W-1:0] b);
    frame_reply_t               r;
    logic [srfr_pkg::CHK_W-1:0] sum;
    if (b == cur_start) begin
      rx_pos = '0;
    end else if (rx_pos < srfr_pkg::POS_LIMIT) begin
      rx_pos = rx_pos + 1'b1;
    end
    if (rx_pos < srfr_pkg::STORE_DEPTH) begin
      frame_bytes[rx_pos] = b;
    end
    if (b == cur_end && rx_pos == srfr_pkg::END_POSITION) begin
      if (frames_done < srfr_pkg::COUNT_MAX) begin
        frames_done = frames_done + 1'b1;
      end else begin
        past_saturation++;
      end
      if (frames_done != 1) begin
        r.st = srfr_pkg::ST_NOT_FIRST;
      end else begin
        sum = '0;
        for (int i = srfr_pkg::SUM_FIRST; i <= srfr_pkg::SUM_LAST; i++) begin
          sum = sum + {8'h00, frame_bytes[i]};
        end
        sum = ~sum + 1'b1;
        if (sum != {frame_bytes[srfr_pkg::CHK_HI_POS], frame_bytes[srfr_pkg::CHK_LO_POS]}) begin
          r.st = srfr_pkg::ST_CHK_ERR;
        end else if (frame_bytes[srfr_pkg::CMD_POS] == cur_online) begin
          player_ready = 1'b1;
          r.st = srfr_pkg::ST_ONLINE;
        end else begin
          r.st = srfr_pkg::ST_OTHER;
        end
      end
      r.cmd = frame_bytes[srfr_pkg::CMD_POS];
      r.dev = frame_bytes[srfr_pkg::DEV_POS];
      r.count = frames_done;
      r.rdy = player_ready;
      expected_replies.push_back(r);
    end
  endtask

  task automatic check_reply();
    frame_reply_t want;
    if (expected_replies.size() == 0) begin
      flag_mismatch("result with nothing expected", frames_seen, 0);
    end else begin
      want = expected_replies.pop_front();
      if (status !== want.st) flag_mismatch("status", status, want.st);
      if (command_byte !== want.cmd) flag_mismatch("command_byte", command_byte, want.cmd);
      if (device_mask !== want.dev) flag_mismatch("device_mask", device_mask, want.dev);
      if (frames_seen !== want.count) flag_mismatch("frames_seen", frames_seen, want.count);
      if (ready_flag !== want.rdy) flag_mismatch("ready_flag", ready_flag, want.rdy);
      replies_checked++;
    end
  endtask

  // Driver: hold the item until accepted, then wait out the gap before the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_rx_byte(rx_byte);
        bytes_taken++;
      end
      if (in_valid && !in_ready) begin
        send_gap = send_gap;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_valid <= 1'b1;
        rx_byte <= pending_bytes.pop_front();
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each reply, then stall the receiver at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_reply();
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        recv_stall = pick_gap();
        out_ready <= (recv_stall == 0);
        if (recv_stall > 0) recv_stall--;
      end else begin
        out_ready <= calm || ($urandom_range(0, 7) != 0);
      end
    end
  end

  task automatic queue_byte(input logic [srfr_pkg::BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  function automatic logic [srfr_pkg::BYTE_W-1:0] body_byte();
    logic [srfr_pkg::BYTE_W-1:0] b;
    b = 8'($urandom);
    if (b == cur_start) b = b + 1'b1;
    return b;
  endfunction

  task automatic queue_frame(input bit good_sum, input logic [srfr_pkg::BYTE_W-1:0] cmd);
    logic [srfr_pkg::BYTE_W-1:0] f [1:srfr_pkg::END_POSITION];
    logic [srfr_pkg::CHK_W-1:0]  sum;
    for (int i = 1; i <= srfr_pkg::END_POSITION; i++) f[i] = body_byte();
    f[srfr_pkg::CMD_POS] = cmd;
    sum = '0;
    for (int i = srfr_pkg::SUM_FIRST; i <= srfr_pkg::SUM_LAST; i++) begin
      sum = sum + {8'h00, f[i]};
    end
    sum = ~sum + 1'b1;
    f[srfr_pkg::CHK_HI_POS] = sum[15:8];
    f[srfr_pkg::CHK_LO_POS] = sum[7:0];
    if (!good_sum) begin
      if ($urandom_range(0, 1)) f[srfr_pkg::CHK_HI_POS][$urandom_range(0, 7)] ^= 1'b1;
      else f[srfr_pkg::CHK_LO_POS][$urandom_range(0, 7)] ^= 1'b1;
    end
    f[srfr_pkg::END_POSITION] = cur_end;
    queue_byte(cur_start);
    for (int i = 1; i <= srfr_pkg::END_POSITION; i++) queue_byte(f[i]);
  endtask

  // Mostly well-formed frames; else noise, cut-short, overlong, badly ended or lone markers
  task automatic fill_phase(input int n);
    int                          first;
    int                          k;
    logic [srfr_pkg::BYTE_W-1:0] b;
    first = bytes_queued;
    while (bytes_queued - first < n) begin
      k = $urandom_range(0, 99);
      if (k < 75) begin
        queue_frame($urandom_range(0, 9) != 0,
                    ($urandom_range(0, 3) == 0) ? cur_online : body_byte());
      end else if (k < 81) begin
        repeat ($urandom_range(1, 12)) queue_byte(8'($urandom));
      end else if (k < 86) begin
        queue_byte(cur_start);
        repeat ($urandom_range(1, srfr_pkg::END_POSITION - 1)) queue_byte(body_byte());
      end else if (k < 91) begin
        queue_byte(cur_start);
        repeat ($urandom_range(srfr_pkg::END_POSITION, srfr_pkg::END_POSITION + 3)) begin
          queue_byte(body_byte());
        end
        queue_byte(cur_end);
      end else if (k < 96) begin
        queue_byte(cur_start);
        repeat (srfr_pkg::END_POSITION - 1) queue_byte(body_byte());
        b = body_byte();
        if (b == cur_end) b = b ^ 8'h01;
        queue_byte(b);
      end else begin
        queue_byte($urandom_range(0, 1) ? cur_end : cur_start);
      end
    end
  endtask

  task automatic write_reg(input logic [srfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srfr_pkg::BYTE_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      srfr_pkg::REG_START_VALUE:    cur_start = val;
      srfr_pkg::REG_END_VALUE:      cur_end = val;
      srfr_pkg::REG_ONLINE_COMMAND: cur_online = val;
      default:                      cur_start = cur_start;
    endcase
  endtask

  // Hold off until every byte is taken and every reply has come back
  task automatic drain();
    while (bytes_taken != bytes_queued) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    int                          phase;
    logic [srfr_pkg::BYTE_W-1:0] s;
    logic [srfr_pkg::BYTE_W-1:0] e;
    logic [srfr_pkg::BYTE_W-1:0] o;
    logic [srfr_pkg::BYTE_W-1:0] b;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Position advance from reset, then the one first frame
    queue_byte(8'h00);
    queue_byte(8'hFF);
    case ($urandom_range(0, 2))
      0:       queue_frame(1'b1, cur_online);
      1:       queue_frame(1'b1, ~cur_online);
      default: queue_frame(1'b0, cur_online);
    endcase
    // Overlong frame: end value arrives one position late
    queue_byte(cur_start);
    repeat (srfr_pkg::END_POSITION - 1) queue_byte(body_byte());
    b = body_byte();
    if (b == cur_end) b = b ^ 8'h01;
    queue_byte(b);
    queue_byte(cur_end);
    drain();

    phase = 0;
    while (bytes_queued < 1100) begin
      case (phase)
        0:       {s, e, o} = {8'd0, 8'd255, 8'd0};
        1:       {s, e, o} = {8'd255, 8'd0, 8'd255};
        2:       {s, e, o} = {srfr_pkg::START_VALUE_RST, srfr_pkg::END_VALUE_RST,
                              srfr_pkg::ONLINE_COMMAND_RST};
        3:       {s, e, o} = {8'h5A, 8'h5A, 8'(($urandom))};
        default: {s, e, o} = {8'($urandom), 8'($urandom), 8'($urandom)};
      endcase
      write_reg(srfr_pkg::REG_START_VALUE, s);
      write_reg(srfr_pkg::REG_END_VALUE, e);
      write_reg(srfr_pkg::REG_ONLINE_COMMAND, o);
      calm = (phase % 4 == 1);
      fill_phase((s == e) ? 40 : 150);
      drain();
      phase++;
    end

    if (expected_replies.size() != 0) begin
      flag_mismatch("replies never produced", 0, expected_replies.size());
    end
    $display("%0d bytes over %0d register settings, %0d frame replies checked",
             bytes_taken, phase + 1, replies_checked);
    $display("%0d frames past counter saturation; overlong, cut and noise bytes mixed in",
             past_saturation);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
